[src/dtce_pkg.sv]
// Shared types, constants and calendar tables for the datetime check and encode unit.
package dtce_pkg;

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 48;

    localparam logic [11:0] YEAR_MIN      = 12'd2000;
    localparam logic [11:0] YEAR_MAX      = 12'd2099;
    localparam logic [6:0]  FAT_YEAR_BIAS = 7'd20;
    localparam logic [4:0]  HOUR_MAX      = 5'd23;
    localparam logic [5:0]  MINUTE_MAX    = 6'd59;
    localparam logic [5:0]  SECOND_MAX    = 6'd59;
    localparam logic [2:0]  SUNDAY        = 3'd7;
    localparam logic [7:0]  PRE_MARCH_1999 = 8'd5;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } t_dt_in;

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] d;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = leap ? 5'd29 : 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

    function automatic logic [2:0] month_offset(input logic [3:0] month);
        logic [2:0] o;
        case (month)
            4'd1:    o = 3'd0;
            4'd2:    o = 3'd3;
            4'd3:    o = 3'd2;
            4'd4:    o = 3'd5;
            4'd5:    o = 3'd0;
            4'd6:    o = 3'd3;
            4'd7:    o = 3'd5;
            4'd8:    o = 3'd1;
            4'd9:    o = 3'd4;
            4'd10:   o = 3'd6;
            4'd11:   o = 3'd2;
            4'd12:   o = 3'd4;
            default: o = 3'd0;
        endcase
        return o;
    endfunction

    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [15:0] p;
        logic [7:0]  q;
        logic [7:0]  r;
        p = 16'(x) * 16'd73;
        q = {1'b0, p[15:9]};
        r = x - 8'(q * 8'd7);
        if (r >= 8'd7) begin
            r = r - 8'd7;
        end
        return r[2:0];
    endfunction

endpackage

[src/datetime_check_and_encode_unit.sv]
// Top level: two-register datetime check, weekday and FAT timestamp encoder.
// Takes one date/time word per cycle on the slave stream while the output is not stalled
// (throughput one word per clock) and returns one result word per input word on the master
// stream, via the input and result registers. The result register advances when empty or
// being taken, the input register when empty or when the result register advances. valid_res
// travels in tuser; when it is low, weekday, year_offset and fat_stamp are zero. Years 2000
// to 2099, Gregorian leap rules, weekday 1 = Monday to 7 = Sunday, FAT seconds halved.
module datetime_check_and_encode_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26], second[37:32]
    input  logic [dtce_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // weekday[2:0], year_offset[9:3], fat_stamp[41:10]
    output logic [dtce_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // valid_res[0]
    output logic                             m_axis_tuser
);
    import dtce_pkg::*;

    logic       r_in_valid;
    t_dt_in     r_in;
    logic       r_out_valid;
    logic       r_valid_res;
    logic [2:0] r_weekday;
    logic [6:0] r_year_offset;
    logic [31:0] r_fat_stamp;

    logic        out_en;
    logic        in_en;
    logic        n_valid_res;
    logic [2:0]  n_weekday;
    logic [6:0]  n_year_offset;
    logic [31:0] n_fat_stamp;

    logic       year_ok;
    logic       month_ok;
    logic       day_ok;
    logic       time_ok;
    logic       leap;
    logic       early;
    logic [6:0] year_off;
    logic [6:0] adj_year;
    logic [4:0] mlen;
    logic [7:0] base;
    logic [7:0] sum;
    logic [2:0] rem;

    assign out_en        = !r_out_valid || m_axis_tready;
    assign in_en         = !r_in_valid || out_en;
    assign s_axis_tready = in_en;

    always_comb begin
        year_ok  = (r_in.year >= YEAR_MIN) && (r_in.year <= YEAR_MAX);
        month_ok = r_in.month inside {[4'd1:4'd12]};
        year_off = 7'(r_in.year - YEAR_MIN);
        leap     = (year_off[1:0] == 2'b00);
        mlen     = month_days(r_in.month, leap);
        day_ok   = (r_in.day != 5'd0) && (r_in.day <= mlen);
        time_ok  = (r_in.hour <= HOUR_MAX) && (r_in.minute <= MINUTE_MAX)
                && (r_in.second <= SECOND_MAX);
        early    = (r_in.month < 4'd3);
        adj_year = year_off - {6'd0, early};
        if (early && (year_off == 7'd0)) begin
            base = PRE_MARCH_1999;
        end else begin
            base = {1'b0, adj_year} + {3'd0, adj_year[6:2]};
        end
        sum = base + {5'd0, month_offset(r_in.month)} + {3'd0, r_in.day};
        rem = mod7(sum);

        n_valid_res = year_ok && month_ok && day_ok && time_ok;
        if (n_valid_res) begin
            n_weekday     = (rem == 3'd0) ? SUNDAY : rem;
            n_year_offset = year_off;
            n_fat_stamp   = {year_off + FAT_YEAR_BIAS, r_in.month, r_in.day, r_in.hour,
                             r_in.minute, r_in.second[5:1]};
        end else begin
            n_weekday     = 3'd0;
            n_year_offset = 7'd0;
            n_fat_stamp   = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_en) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_en) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_en && s_axis_tvalid) begin
            r_in <= t_dt_in'(s_axis_tdata[$bits(t_dt_in)-1:0]);
        end
        if (out_en && r_in_valid) begin
            r_valid_res   <= n_valid_res;
            r_weekday     <= n_weekday;
            r_year_offset <= n_year_offset;
            r_fat_stamp   <= n_fat_stamp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_valid_res;
    assign m_axis_tdata  = {(OUT_DATA_W - 42)'(0), r_fat_stamp, r_year_offset, r_weekday};

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking stream testbench for the datetime check and encode unit.
module tb_top;
    import dtce_pkg::*;

    localparam int CYCLE_LIMIT = 60000;
    localparam int RAND_ITEMS  = 450;
    localparam int DT_W        = $bits(t_dt_in);
    localparam int STALL_LEN   = 80;

    typedef struct packed {
        logic        valid_res;
        logic [2:0]  weekday;
        logic [6:0]  year_offset;
        logic [31:0] fat_stamp;
    } t_stamp;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    t_dt_in dt_q[$];
    t_stamp stamp_q[$];
    int     n_total    = 1;
    int     n_sent     = 0;
    int     n_err      = 0;
    int     n_cycles   = 0;
    int     stall_left = 0;
    logic   stall_done = 1'b0;
    logic   draining   = 1'b0;
    logic   drain_done = 1'b0;
    int     idle_phase;

    assign idle_phase = (n_sent * 3) / n_total;

    datetime_check_and_encode_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit is_leap(int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
        int unsigned len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == 2 && is_leap(y)) begin
            return 29;
        end
        return len[m - 1];
    endfunction

    function automatic t_stamp encode_datetime(t_dt_in dt);
        int unsigned shift [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
        t_stamp      r;
        int unsigned y;
        int unsigned wd;
        bit          ok;
        r  = '0;
        y  = dt.year;
        ok = (dt.year >= YEAR_MIN) && (dt.year <= YEAR_MAX) && (dt.month >= 1)
            && (dt.month <= 12) && (dt.hour <= HOUR_MAX) && (dt.minute <= MINUTE_MAX)
            && (dt.second <= SECOND_MAX);
        if (ok) begin
            ok = (dt.day >= 1) && (dt.day <= days_in_month(dt.year, dt.month));
        end
        if (ok) begin
            if (dt.month < 3) begin
                y = y - 1;
            end
            wd = (y + y / 4 - y / 100 + y / 400 + shift[dt.month - 1] + dt.day) % 7;
            r.valid_res   = 1'b1;
            r.weekday     = (wd == 0) ? SUNDAY : 3'(wd);
            r.year_offset = 7'(dt.year - YEAR_MIN);
            r.fat_stamp   = {7'(dt.year - 12'd1980), dt.month, dt.day, dt.hour, dt.minute,
                             5'(dt.second >> 1)};
        end
        return r;
    endfunction

    function automatic t_dt_in make_dt(int unsigned y, int unsigned mo, int unsigned d,
                                       int unsigned h, int unsigned mi, int unsigned s);
        t_dt_in dt;
        dt.year   = 12'(y);
        dt.month  = 4'(mo);
        dt.day    = 5'(d);
        dt.hour   = 5'(h);
        dt.minute = 6'(mi);
        dt.second = 6'(s);
        return dt;
    endfunction

    function automatic int unsigned idle_pct(int phase, bit sender);
        case (phase)
            0:       return sender ? 32 : 56;
            1:       return sender ? 56 : 32;
            default: return 0;
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            n_err++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    initial begin
        int unsigned y;
        int unsigned mo;
        int unsigned sel;
        t_dt_in      dt;
        dt_q.push_back(make_dt(2000, 1, 1, 0, 0, 0));
        dt_q.push_back(make_dt(2099, 12, 31, 23, 59, 59));
        dt_q.push_back(make_dt(2000, 2, 29, 12, 30, 31));
        dt_q.push_back(make_dt(2004, 2, 29, 1, 2, 3));
        dt_q.push_back(make_dt(2001, 2, 29, 1, 2, 3));
        dt_q.push_back(make_dt(2003, 2, 28, 23, 0, 1));
        dt_q.push_back(make_dt(2000, 3, 1, 0, 0, 58));
        dt_q.push_back(make_dt(2023, 1, 1, 10, 10, 10));
        dt_q.push_back(make_dt(2000, 1, 2, 6, 7, 8));
        dt_q.push_back(make_dt(1999, 12, 31, 23, 59, 59));
        dt_q.push_back(make_dt(2100, 1, 1, 0, 0, 0));
        dt_q.push_back(make_dt(2100, 2, 29, 0, 0, 0));
        dt_q.push_back(make_dt(0, 0, 0, 0, 0, 0));
        dt_q.push_back(make_dt(4095, 15, 31, 31, 63, 63));
        dt_q.push_back(make_dt(2050, 0, 10, 5, 5, 5));
        dt_q.push_back(make_dt(2050, 13, 10, 5, 5, 5));
        dt_q.push_back(make_dt(2050, 6, 0, 5, 5, 5));
        dt_q.push_back(make_dt(2050, 4, 31, 5, 5, 5));
        dt_q.push_back(make_dt(2050, 6, 30, 24, 5, 5));
        dt_q.push_back(make_dt(2050, 6, 30, 5, 60, 5));
        dt_q.push_back(make_dt(2050, 6, 30, 5, 5, 60));
        dt_q.push_back(make_dt(2077, 11, 15, 13, 45, 59));
        for (int i = 0; i < RAND_ITEMS; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                y  = $urandom_range(2000, 2099);
                mo = $urandom_range(1, 12);
                dt = make_dt(y, mo, $urandom_range(1, days_in_month(y, mo)),
                             $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
            end else if (sel < 85) begin
                dt = make_dt($urandom_range(1998, 2101), $urandom_range(0, 13),
                             $urandom_range(0, 31), $urandom_range(22, 25),
                             $urandom_range(58, 63), $urandom_range(58, 63));
            end else begin
                dt = t_dt_in'(DT_W'({$urandom(), $urandom()}));
            end
            dt_q.push_back(dt);
        end
        n_total = dt_q.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (dt_q.size() != 0 || s_tvalid || stamp_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (n_err == 0) begin
            $display("datetime_check_and_encode_unit verification clean");
        end else begin
            $display("datetime_check_and_encode_unit verification failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                stamp_q.push_back(encode_datetime(t_dt_in'(s_tdata[DT_W-1:0])));
                n_sent <= n_sent + 1;
            end
            if (!drain_done && !draining && n_sent == n_total / 2) begin
                draining = 1'b1;
            end
            if (draining && !s_tvalid && stamp_q.size() == 0) begin
                draining   = 1'b0;
                drain_done = 1'b1;
            end
            if (!s_tvalid || s_tready) begin
                if (!draining && dt_q.size() != 0
                    && $urandom_range(0, 99) >= idle_pct(idle_phase, 1'b1)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_DATA_W'(dt_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!stall_done && n_sent == n_total - 100) begin
            stall_left <= STALL_LEN;
            stall_done <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge i_clk) begin
        t_stamp want;
        t_stamp got;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.valid_res   = m_tuser;
                got.weekday     = m_tdata[2:0];
                got.year_offset = m_tdata[9:3];
                got.fat_stamp   = m_tdata[41:10];
                if (stamp_q.size() == 0) begin
                    n_err++;
                    $display("%0t: result word with none expected: expected none, actual %h",
                             $time, got);
                end else begin
                    want = stamp_q.pop_front();
                    check_field("valid_res", 32'(want.valid_res), 32'(got.valid_res));
                    check_field("weekday", 32'(want.weekday), 32'(got.weekday));
                    check_field("year_offset", 32'(want.year_offset), 32'(got.year_offset));
                    check_field("fat_stamp", want.fat_stamp, got.fat_stamp);
                end
            end
            m_tready <= (stall_left == 0) && ($urandom_range(0, 99) >= idle_pct(idle_phase, 1'b0));
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("datetime_check_and_encode_unit verification failed");
            $finish;
        end
    end

endmodule
